### sv/assert_macros.svh
// assert_macros.svh - shared assertion macros for the helical point transform checks
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, switched off while reset is held.
`define HPT_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Clocked assertion that also holds through reset.
`define HPT_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);

`endif

### sv/hpt_pkg.sv
// ----------------------------------------------------------------------------
// hpt_pkg - shared constants, types and tables
// Widths, pipeline depth, register indexes and the CORDIC angle table.
// ----------------------------------------------------------------------------
`default_nettype none
package hpt_pkg;

    localparam int RADIAL_W         = 8;
    localparam int ANGLE_W          = 10;
    localparam int MAX_RADIAL_INDEX = 255;
    localparam int MAX_ANGLE_INDEX  = 1023;
    localparam int CORDIC_STAGES    = 16;
    localparam int ATAN_ENTRIES     = 30;
    localparam int CORDIC_N = (CORDIC_STAGES < ATAN_ENTRIES) ? CORDIC_STAGES : ATAN_ENTRIES;

    localparam int STEP_W   = 31;
    localparam int WORD_W   = 32;
    localparam int ROW_W    = 48;
    localparam int COEF_W   = 16;
    localparam int RADIUS_W = STEP_W + RADIAL_W;   // 39
    localparam int GAIN_W   = 30;
    localparam logic [GAIN_W-1:0] INV_GAIN = 30'd652032874;
    localparam int CW       = RADIUS_W + 2;        // CORDIC x/y width
    localparam int RES_W    = 33;                  // residual phase width
    localparam int Z_W      = 44;
    localparam int OUT_W    = 32;

    // four front stages, the CORDIC stages, four matrix stages
    localparam int NS       = CORDIC_N + 8;
    localparam int CORDIC_BASE = 4;
    localparam int MATRIX_BASE = CORDIC_BASE + CORDIC_N;

    localparam int IDX_W = 3;
    typedef enum logic [IDX_W-1:0] {
        REG_RADIAL_STEP  = 3'd0,
        REG_ANGLE_STEP   = 3'd1,
        REG_Z_STEP       = 3'd2,
        REG_Z_OFFSET     = 3'd3,
        REG_MATRIX_ROW_X = 3'd4,
        REG_MATRIX_ROW_Y = 3'd5,
        REG_MATRIX_ROW_Z = 3'd6
    } cfg_index_t;

    typedef logic [2:0][ROW_W-1:0] matrix_t;

    // atan(2^-k) in units of 2^-32 turn
    function automatic logic [WORD_W-1:0] atan_turn(input int k);
        logic [WORD_W-1:0] v;
        unique case (k)
            0:  v = 32'h20000000;  1:  v = 32'h12E4051E;  2:  v = 32'h09FB385B;
            3:  v = 32'h051111D4;  4:  v = 32'h028B0D43;  5:  v = 32'h0145D7E1;
            6:  v = 32'h00A2F61E;  7:  v = 32'h00517C55;  8:  v = 32'h0028BE53;
            9:  v = 32'h00145F2F;  10: v = 32'h000A2F98;  11: v = 32'h000517CC;
            12: v = 32'h00028BE6;  13: v = 32'h000145F3;  14: v = 32'h0000A2FA;
            15: v = 32'h0000517D;  16: v = 32'h000028BE;  17: v = 32'h0000145F;
            18: v = 32'h00000A30;  19: v = 32'h00000518;  20: v = 32'h0000028C;
            21: v = 32'h00000146;  22: v = 32'h000000A3;  23: v = 32'h00000051;
            24: v = 32'h00000029;  25: v = 32'h00000014;  26: v = 32'h0000000A;
            27: v = 32'h00000005;  28: v = 32'h00000003;  29: v = 32'h00000001;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

### sv/helical_point_transform_unit.sv
// Pipeline: the front stages, the CORDIC stages and the matrix stages, from input accept to result.
// Throughput: one item per cycle while the output is not stalled; the CORDIC rotator has one register per stage.
// Each stage holds its own valid bit, so bubbles close up behind a stalled output.
// Reset (aresetn low, synchronous) empties the pipeline and restores the default
// registers: unit radial step, zero angle and height, identity matrix.
`default_nettype none
module helical_point_transform_unit import hpt_pkg::*; (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    // tdata: radial_index [7:0], angle_index [17:8], zero pad [23:18]
    input  wire logic [23:0]        s_tdata,
    input  wire logic               s_tvalid,
    output logic                    s_tready,
    // tdata: global_x [31:0], global_y [63:32], global_z [95:64]
    output logic [95:0]             m_tdata,
    output logic                    m_tvalid,
    input  wire logic               m_tready,
    input  wire logic               cfg_we,
    input  wire logic [IDX_W-1:0]   cfg_index,
    input  wire logic [ROW_W-1:0]   cfg_wdata
);
    // ---------------- configuration registers ----------------
    logic [STEP_W-1:0] radial_step_reg;
    logic [WORD_W-1:0] angle_step_reg, z_step_reg, z_offset_reg;
    matrix_t           matrix_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            radial_step_reg <= STEP_W'(65536);
            angle_step_reg  <= '0;
            z_step_reg      <= '0;
            z_offset_reg    <= '0;
            matrix_reg[0]   <= ROW_W'(48'd16384);
            matrix_reg[1]   <= ROW_W'(48'd1073741824);
            matrix_reg[2]   <= ROW_W'(48'd70368744177664);
        end else if (cfg_we) begin
            // drop writes to indexes beyond the register list
            unique case (cfg_index_t'(cfg_index))
                REG_RADIAL_STEP:  radial_step_reg <= cfg_wdata[STEP_W-1:0];
                REG_ANGLE_STEP:   angle_step_reg  <= cfg_wdata[WORD_W-1:0];
                REG_Z_STEP:       z_step_reg      <= cfg_wdata[WORD_W-1:0];
                REG_Z_OFFSET:     z_offset_reg    <= cfg_wdata[WORD_W-1:0];
                REG_MATRIX_ROW_X: matrix_reg[0]   <= cfg_wdata;
                REG_MATRIX_ROW_Y: matrix_reg[1]   <= cfg_wdata;
                REG_MATRIX_ROW_Z: matrix_reg[2]   <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // ---------------- pipeline flow control ----------------
    // A stage advances when it is empty or the stage after it advances.
    logic [NS-1:0] valid_reg, valid_next;
    logic [NS:0]   ready;

    always_comb begin
        ready[NS] = m_tready;
        for (int k = NS - 1; k >= 0; k--) begin
            ready[k] = !valid_reg[k] || ready[k+1];
        end
    end

    always_comb begin
        for (int k = 0; k < NS; k++) begin
            if (ready[k]) begin
                valid_next[k] = (k == 0) ? s_tvalid : valid_reg[(k == 0) ? 0 : k - 1];
            end else begin
                valid_next[k] = valid_reg[k];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    assign s_tready = ready[0];
    assign m_tvalid = valid_reg[NS-1];

    // ---------------- datapath ----------------
    logic [RADIUS_W-1:0]     x0;
    logic signed [RES_W-1:0] res0;
    logic [1:0]              quad_f, quad_c;
    logic signed [Z_W-1:0]   z_f, z_c;
    logic signed [CW-1:0]    x_c, y_c;
    logic [2:0][OUT_W-1:0]   result;

    hpt_front u_front (
        .aclk         (aclk),
        .en           (ready[3:0]),
        .radial_index (s_tdata[RADIAL_W-1:0]),
        .angle_index  (s_tdata[RADIAL_W+ANGLE_W-1:RADIAL_W]),
        .radial_step  (radial_step_reg),
        .angle_step   (angle_step_reg),
        .z_step       (z_step_reg),
        .z_offset     (z_offset_reg),
        .x0           (x0),
        .res0         (res0),
        .quad         (quad_f),
        .z            (z_f)
    );

    hpt_cordic u_cordic (
        .aclk     (aclk),
        .en       (ready[MATRIX_BASE-1:CORDIC_BASE]),
        .x0       (x0),
        .res0     (res0),
        .quad_in  (quad_f),
        .z_in     (z_f),
        .x_out    (x_c),
        .y_out    (y_c),
        .quad_out (quad_c),
        .z_out    (z_c)
    );

    hpt_matrix u_matrix (
        .aclk   (aclk),
        .en     (ready[NS-1:MATRIX_BASE]),
        .rows   (matrix_reg),
        .x_in   (x_c),
        .y_in   (y_c),
        .quad   (quad_c),
        .z_in   (z_c),
        .result (result)
    );

    assign m_tdata = {result[2], result[1], result[0]};
endmodule
`default_nettype wire

### sv/hpt_front.sv
// ----------------------------------------------------------------------------
// hpt_front - radius, gain, phase split and height
// Four stages: input capture, clamp and step products, gain partial products, gain sum.
// ----------------------------------------------------------------------------
`default_nettype none
module hpt_front import hpt_pkg::*; (
    input  wire logic                     aclk,
    input  wire logic [3:0]               en,
    input  wire logic [RADIAL_W-1:0]      radial_index,
    input  wire logic [ANGLE_W-1:0]       angle_index,
    input  wire logic [STEP_W-1:0]        radial_step,
    input  wire logic [WORD_W-1:0]        angle_step,
    input  wire logic [WORD_W-1:0]        z_step,
    input  wire logic [WORD_W-1:0]        z_offset,
    output logic [RADIUS_W-1:0]           x0,
    output logic signed [RES_W-1:0]       res0,
    output logic [1:0]                    quad,
    output logic signed [Z_W-1:0]         z
);
    localparam int RL_W = 20;
    localparam int RH_W = RADIUS_W - RL_W;
    localparam int SUM_W = RH_W + GAIN_W + RL_W + 1;

    logic [RADIAL_W-1:0] i_reg, i_next;
    logic [ANGLE_W-1:0]  j_reg, j_next;
    logic [RADIUS_W-1:0] r_reg;
    logic [WORD_W-1:0]   phase_reg;
    logic signed [Z_W-1:0] z1_reg, z2_reg, z3_reg;
    logic [RH_W+GAIN_W-1:0] ph_reg;
    logic [RL_W+GAIN_W-1:0] pl_reg;
    logic [1:0] q2_reg, q3_reg;
    logic signed [RES_W-1:0] res2_reg, res3_reg;
    logic [RADIUS_W-1:0] x3_reg;
    logic [WORD_W-1:0] phase_adj, resid;
    logic [1:0] q_next;
    logic [SUM_W-1:0] gain_sum;

    // clamp indices
    always_comb begin
        i_next = (i_reg > RADIAL_W'(MAX_RADIAL_INDEX)) ? RADIAL_W'(MAX_RADIAL_INDEX) : i_reg;
        j_next = (j_reg > ANGLE_W'(MAX_ANGLE_INDEX)) ? ANGLE_W'(MAX_ANGLE_INDEX) : j_reg;
    end

    always_ff @(posedge aclk) begin
        if (en[0]) begin
            i_reg <= radial_index;
            j_reg <= angle_index;
        end
    end

    always_ff @(posedge aclk) begin
        if (en[1]) begin
            r_reg     <= RADIUS_W'(radial_step * i_next);
            phase_reg <= WORD_W'(angle_step * j_next);
            z1_reg    <= Z_W'($signed(z_step) * $signed({1'b0, j_next}))
                         - Z_W'($signed(z_offset));
        end
    end

    // split phase into quadrant and residual
    always_comb begin
        phase_adj = phase_reg + 32'h2000_0000;
        q_next    = phase_adj[WORD_W-1:WORD_W-2];
        resid     = phase_reg - {q_next, 30'd0};
    end

    always_ff @(posedge aclk) begin
        if (en[2]) begin
            ph_reg   <= r_reg[RADIUS_W-1:RL_W] * INV_GAIN;
            pl_reg   <= r_reg[RL_W-1:0] * INV_GAIN;
            q2_reg   <= q_next;
            res2_reg <= RES_W'($signed(resid));
            z2_reg   <= z1_reg;
        end
    end

    assign gain_sum = {1'b0, ph_reg, {RL_W{1'b0}}} + SUM_W'(pl_reg) + (SUM_W'(1) << 29);

    always_ff @(posedge aclk) begin
        if (en[3]) begin
            x3_reg   <= gain_sum[RADIUS_W+GAIN_W-1:GAIN_W];
            q3_reg   <= q2_reg;
            res3_reg <= res2_reg;
            z3_reg   <= z2_reg;
        end
    end

    assign x0   = x3_reg;
    assign res0 = res3_reg;
    assign quad = q3_reg;
    assign z    = z3_reg;
endmodule
`default_nettype wire

### sv/hpt_cordic.sv
// ----------------------------------------------------------------------------
// hpt_cordic - rotation-mode CORDIC, one stage per register
// ----------------------------------------------------------------------------
`default_nettype none
module hpt_cordic import hpt_pkg::*; (
    input  wire logic                     aclk,
    input  wire logic [CORDIC_N-1:0]      en,
    input  wire logic [RADIUS_W-1:0]      x0,
    input  wire logic signed [RES_W-1:0]  res0,
    input  wire logic [1:0]               quad_in,
    input  wire logic signed [Z_W-1:0]    z_in,
    output logic signed [CW-1:0]          x_out,
    output logic signed [CW-1:0]          y_out,
    output logic [1:0]                    quad_out,
    output logic signed [Z_W-1:0]         z_out
);
    logic signed [CW-1:0]    x_reg   [CORDIC_N];
    logic signed [CW-1:0]    y_reg   [CORDIC_N];
    logic signed [RES_W-1:0] res_reg [CORDIC_N];
    logic [1:0]              q_reg   [CORDIC_N];
    logic signed [Z_W-1:0]   z_reg   [CORDIC_N];

    for (genvar k = 0; k < CORDIC_N; k++) begin : g_stage
        logic signed [CW-1:0]    xi, yi, x_next, y_next;
        logic signed [RES_W-1:0] ri, res_next;
        logic [1:0]              qi;
        logic signed [Z_W-1:0]   zi;
        localparam logic signed [RES_W-1:0] ANG = RES_W'(atan_turn(k));

        if (k == 0) begin : g_in
            assign xi = CW'($signed({1'b0, x0}));
            assign yi = '0;
            assign ri = res0;
            assign qi = quad_in;
            assign zi = z_in;
        end else begin : g_chain
            assign xi = x_reg[k-1];
            assign yi = y_reg[k-1];
            assign ri = res_reg[k-1];
            assign qi = q_reg[k-1];
            assign zi = z_reg[k-1];
        end

        // turn positive when the residual is not negative
        always_comb begin
            if (!ri[RES_W-1]) begin
                x_next   = xi - (yi >>> k);
                y_next   = yi + (xi >>> k);
                res_next = ri - ANG;
            end else begin
                x_next   = xi + (yi >>> k);
                y_next   = yi - (xi >>> k);
                res_next = ri + ANG;
            end
        end

        always_ff @(posedge aclk) begin
            if (en[k]) begin
                x_reg[k]   <= x_next;
                y_reg[k]   <= y_next;
                res_reg[k] <= res_next;
                q_reg[k]   <= qi;
                z_reg[k]   <= zi;
            end
        end
    end

    assign x_out    = x_reg[CORDIC_N-1];
    assign y_out    = y_reg[CORDIC_N-1];
    assign quad_out = q_reg[CORDIC_N-1];
    assign z_out    = z_reg[CORDIC_N-1];
endmodule
`default_nettype wire

### sv/hpt_matrix.sv
// ----------------------------------------------------------------------------
// hpt_matrix - quadrant turn, 3x3 Q2.14 product, rounding and saturation
// ----------------------------------------------------------------------------
`default_nettype none
module hpt_matrix import hpt_pkg::*; (
    input  wire logic                   aclk,
    input  wire logic [3:0]             en,
    input  wire matrix_t                rows,
    input  wire logic signed [CW-1:0]   x_in,
    input  wire logic signed [CW-1:0]   y_in,
    input  wire logic [1:0]             quad,
    input  wire logic signed [Z_W-1:0]  z_in,
    output logic [2:0][OUT_W-1:0]       result
);
    localparam int PXY_W = COEF_W + CW;
    localparam int PZ_W  = COEF_W + Z_W;
    localparam int SUM_W = PZ_W + 2;
    localparam int SH_W  = SUM_W - 14;

    logic signed [CW-1:0]  lx_reg, ly_reg, lx_next, ly_next;
    logic signed [Z_W-1:0] lz_reg;
    logic signed [PXY_W-1:0] pa_reg [3];
    logic signed [PXY_W-1:0] pb_reg [3];
    logic signed [PZ_W-1:0]  pc_reg [3];
    logic signed [SH_W-1:0]  s_reg  [3];
    logic [2:0][OUT_W-1:0]   out_reg;

    // exact quarter turns
    always_comb begin
        unique case (quad)
            2'd1:    begin lx_next = -y_in; ly_next = x_in;  end
            2'd2:    begin lx_next = -x_in; ly_next = -y_in; end
            2'd3:    begin lx_next = y_in;  ly_next = -x_in; end
            default: begin lx_next = x_in;  ly_next = y_in;  end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (en[0]) begin
            lx_reg <= lx_next;
            ly_reg <= ly_next;
            lz_reg <= z_in;
        end
    end

    for (genvar r = 0; r < 3; r++) begin : g_row
        logic signed [SUM_W-1:0] sum;
        logic signed [SUM_W-1:0] shifted;
        logic [OUT_W-1:0]        sat;

        always_ff @(posedge aclk) begin
            if (en[1]) begin
                pa_reg[r] <= $signed(rows[r][COEF_W-1:0]) * lx_reg;
                pb_reg[r] <= $signed(rows[r][2*COEF_W-1:COEF_W]) * ly_reg;
                pc_reg[r] <= $signed(rows[r][3*COEF_W-1:2*COEF_W]) * lz_reg;
            end
        end

        always_comb begin
            sum     = SUM_W'(pa_reg[r]) + SUM_W'(pb_reg[r]) + SUM_W'(pc_reg[r])
                      + SUM_W'(8192);
            shifted = sum >>> 14;
        end

        always_ff @(posedge aclk) begin
            if (en[2]) begin
                s_reg[r] <= shifted[SH_W-1:0];
            end
        end

        // clip to signed 32 bits
        always_comb begin
            if (s_reg[r] > SH_W'(32'sh7FFF_FFFF)) begin
                sat = 32'h7FFF_FFFF;
            end else if (s_reg[r] < SH_W'(-64'sh8000_0000)) begin
                sat = 32'h8000_0000;
            end else begin
                sat = s_reg[r][OUT_W-1:0];
            end
        end

        always_ff @(posedge aclk) begin
            if (en[3]) begin
                out_reg[r] <= sat;
            end
        end
    end

    assign result = out_reg;
endmodule
`default_nettype wire

### sv/hpt_checker.sv
// ----------------------------------------------------------------------------
// hpt_checker - port-level checks on the helical point transform unit
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"
module hpt_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_tready,
    input wire logic [95:0] m_tdata,
    input wire logic        m_tvalid,
    input wire logic        m_tready
);
    // reset empties the pipeline
    `HPT_ASSERT_ALWAYS(a_reset_empty, $past(!aresetn) |-> !m_tvalid, "result after reset")
    // hold a stalled result
    `HPT_ASSERT(a_stall_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "stalled result changed")
    // a free output end leaves the whole pipe free to advance
    `HPT_ASSERT(a_ready_flow, (!m_tvalid || m_tready) |-> s_tready, "input blocked with free output")
endmodule

bind helical_point_transform_unit hpt_checker u_hpt_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tdata  (m_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready)
);
`default_nettype wire

### test/helical_point_transform_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// helical_point_transform_checker - predicts and compares transformed points
// Mirrors the register writes, works out the expected global point for every
// accepted grid item and compares it with each result item in order.
// ----------------------------------------------------------------------------
`default_nettype none
module helical_point_transform_checker import hpt_pkg::*; (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic [23:0]        s_tdata,
    input  wire logic               s_tvalid,
    input  wire logic               s_tready,
    input  wire logic [95:0]        m_tdata,
    input  wire logic               m_tvalid,
    input  wire logic               m_tready,
    input  wire logic               cfg_we,
    input  wire logic [IDX_W-1:0]   cfg_index,
    input  wire logic [ROW_W-1:0]   cfg_wdata,
    output int                      fail_count,
    output int                      points_pending
);

    typedef struct packed {
        logic signed [31:0] gz;
        logic signed [31:0] gy;
        logic signed [31:0] gx;
    } point_t;

    logic [STEP_W-1:0] radial_step;
    logic [31:0]       angle_step;
    logic [31:0]       z_step;
    logic [31:0]       z_offset;
    logic [ROW_W-1:0]  row_x, row_y, row_z;
    point_t            expected_points[$];

    localparam logic [31:0] TURN_ANGLE [30] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
        32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
        32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
        32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
        32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001};

    function automatic logic signed [31:0] matrix_row(input logic [ROW_W-1:0] row,
            input longint a, input longint b, input longint c);
        longint acc;
        acc = longint'($signed(row[15:0])) * a + longint'($signed(row[31:16])) * b
            + longint'($signed(row[47:32])) * c;
        acc = (acc + 8192) >>> 14;
        if (acc > 64'sd2147483647) acc = 64'sd2147483647;
        if (acc < -64'sd2147483648) acc = -64'sd2147483648;
        return acc[31:0];
    endfunction

    function automatic point_t transform_point(input logic [7:0] ri, input logic [9:0] ai);
        longint unsigned radius, rh, rl, q;
        logic [31:0] phase, resid;
        logic [1:0]  quad;
        longint x, y, res, dx, dy, lx, ly, z;
        point_t p;
        radius = longint'(radial_step) * ri;
        phase  = angle_step * ai;
        quad   = 2'((phase + 32'h20000000) >> 30);
        resid  = phase - {quad, 30'd0};
        res    = longint'($signed(resid));
        // split the radius so the gain product stays within 64 bits
        rh = radius >> 20;
        rl = radius & 64'hF_FFFF;
        q  = rh * 64'd652032874;
        x = longint'((q >> 10)
            + ((((q & 64'h3FF) << 20) + rl * 64'd652032874 + (64'd1 << 29)) >> 30));
        y = 0;
        for (int k = 0; k < CORDIC_STAGES && k < 30; k++) begin
            dx = y >>> k;
            dy = x >>> k;
            if (res >= 0) begin
                x -= dx; y += dy; res -= longint'(TURN_ANGLE[k]);
            end else begin
                x += dx; y -= dy; res += longint'(TURN_ANGLE[k]);
            end
        end
        case (quad)
            2'd1: begin lx = -y; ly = x; end
            2'd2: begin lx = -x; ly = -y; end
            2'd3: begin lx = y; ly = -x; end
            default: begin lx = x; ly = y; end
        endcase
        z = longint'($signed(z_step)) * ai - longint'($signed(z_offset));
        p.gx = matrix_row(row_x, lx, ly, z);
        p.gy = matrix_row(row_y, lx, ly, z);
        p.gz = matrix_row(row_z, lx, ly, z);
        return p;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
            input logic [31:0] want);
        $display("MISMATCH %s: got %h, expected %h", what, got, want);
        fail_count++;
    endtask

    assign points_pending = expected_points.size();

    initial fail_count = 0;

    always @(posedge aclk) begin
        point_t got, want;
        if (!aresetn) begin
            radial_step <= STEP_W'(65536);
            angle_step  <= '0;
            z_step      <= '0;
            z_offset    <= '0;
            row_x       <= 48'd16384;
            row_y       <= 48'd1073741824;
            row_z       <= 48'd70368744177664;
            expected_points.delete();
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    REG_RADIAL_STEP:  radial_step <= cfg_wdata[STEP_W-1:0];
                    REG_ANGLE_STEP:   angle_step  <= cfg_wdata[31:0];
                    REG_Z_STEP:       z_step      <= cfg_wdata[31:0];
                    REG_Z_OFFSET:     z_offset    <= cfg_wdata[31:0];
                    REG_MATRIX_ROW_X: row_x       <= cfg_wdata;
                    REG_MATRIX_ROW_Y: row_y       <= cfg_wdata;
                    REG_MATRIX_ROW_Z: row_z       <= cfg_wdata;
                    default: ;
                endcase
            end
            if (m_tvalid && m_tready) begin
                got = m_tdata;
                if (expected_points.size() == 0) begin
                    $display("UNEXPECTED result item %h", m_tdata);
                    fail_count++;
                end else begin
                    want = expected_points.pop_front();
                    if (got.gx !== want.gx) report_mismatch("global_x", got.gx, want.gx);
                    if (got.gy !== want.gy) report_mismatch("global_y", got.gy, want.gy);
                    if (got.gz !== want.gz) report_mismatch("global_z", got.gz, want.gz);
                end
            end
            if (s_tvalid && s_tready)
                expected_points.push_back(transform_point(s_tdata[7:0], s_tdata[17:8]));
        end
    end

endmodule
`default_nettype wire

### test/helical_point_transform_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// helical_point_transform_unit_tb - stimulus and verdict for the transform unit
// Drives grid points under several register settings with random gaps on
// both channels; the checker predicts every point and counts mismatches.
// ----------------------------------------------------------------------------
`default_nettype none
module helical_point_transform_unit_tb;
    import hpt_pkg::*;

    localparam int LATENCY     = CORDIC_STAGES + 8;
    localparam int STALL_LIMIT = 20000;

    logic              aclk = 1'b0;
    logic              aresetn = 1'b0;
    logic [23:0]       s_tdata = '0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [95:0]       m_tdata;
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic              cfg_we = 1'b0;
    logic [IDX_W-1:0]  cfg_index = '0;
    logic [ROW_W-1:0]  cfg_wdata = '0;
    int                fail_count;
    int                points_pending;
    int                idle_cycles = 0;
    bit                hold_receiver = 1'b0;

    always #2 aclk = ~aclk;

    helical_point_transform_unit i_dut (
        .aclk, .aresetn, .s_tdata, .s_tvalid, .s_tready, .m_tdata, .m_tvalid,
        .m_tready, .cfg_we, .cfg_index, .cfg_wdata
    );

    helical_point_transform_checker i_checker (
        .aclk, .aresetn, .s_tdata, .s_tvalid, .s_tready, .m_tdata, .m_tvalid,
        .m_tready, .cfg_we, .cfg_index, .cfg_wdata, .fail_count, .points_pending
    );

    // mostly short gaps, now and then a long one
    function automatic int gap_length();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 50) return 0;
        if (roll < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // receiver: random back-pressure, forced low while a long hold is asked for
    initial begin
        int gap;
        forever begin
            @(negedge aclk);
            if (hold_receiver) begin
                m_tready <= 1'b0;
            end else begin
                gap = gap_length();
                if (gap == 0) begin
                    m_tready <= 1'b1;
                end else begin
                    m_tready <= 1'b0;
                    repeat (gap - 1) @(negedge aclk);
                end
            end
        end
    end

    // watchdog: cycles in which neither channel moves an item
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !aresetn)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    task automatic write_reg(input cfg_index_t idx, input logic [ROW_W-1:0] value);
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(negedge aclk);
        cfg_we    <= 1'b0;
    endtask

    // hold until the checker has seen every expected point, then drain
    task automatic wait_drained();
        while (points_pending != 0) @(negedge aclk);
        repeat (LATENCY + 4) @(negedge aclk);
    endtask

    // offer one item and hold it until it is taken; gaps only when asked
    task automatic send_point(input logic [7:0] ri, input logic [9:0] ai, input bit gaps);
        int gap;
        if (gaps) begin
            gap = gap_length();
            if (gap != 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
        end
        s_tdata  <= {6'd0, ai, ri};
        s_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic stop_sending();
        s_tvalid <= 1'b0;
        @(negedge aclk);
    endtask

    function automatic logic [ROW_W-1:0] random_row();
        return {16'($urandom), 16'($urandom), 16'($urandom)};
    endfunction

    // mostly well-scaled settings, sometimes extreme ones
    task automatic random_settings();
        write_reg(REG_RADIAL_STEP, ($urandom_range(0, 3) == 0) ? 48'($urandom)
                                    : 48'($urandom_range(0, 1 << 20)));
        write_reg(REG_ANGLE_STEP, 48'($urandom));
        write_reg(REG_Z_STEP, 48'($urandom));
        write_reg(REG_Z_OFFSET, 48'($urandom));
        write_reg(REG_MATRIX_ROW_X, random_row());
        write_reg(REG_MATRIX_ROW_Y, random_row());
        write_reg(REG_MATRIX_ROW_Z, random_row());
    endtask

    initial begin
        repeat (4) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed: reset identity, index extremes, then extreme registers
        send_point(8'd0, 10'd0, 1'b0);
        send_point(8'd255, 10'd1023, 1'b0);
        send_point(8'd1, 10'd0, 1'b0);
        send_point(8'd128, 10'd512, 1'b0);
        stop_sending();
        wait_drained();

        write_reg(REG_ANGLE_STEP, 48'h4000_0000);   // quarter turn per step
        write_reg(REG_Z_STEP, 48'h0001_0000);
        write_reg(REG_Z_OFFSET, 48'h0200_0000);
        for (int j = 0; j < 6; j++) send_point(8'd100, 10'(j), 1'b0);
        stop_sending();
        wait_drained();

        // largest values everywhere: phase wrap and saturation both ways
        write_reg(REG_RADIAL_STEP, 48'hFFFF_FFFF_FFFF);
        write_reg(REG_ANGLE_STEP, 48'h0000_FFFF_FFFF);
        write_reg(REG_Z_STEP, 48'h0000_7FFF_FFFF);
        write_reg(REG_Z_OFFSET, 48'h0000_8000_0000);
        write_reg(REG_MATRIX_ROW_X, 48'h7FFF_7FFF_7FFF);
        write_reg(REG_MATRIX_ROW_Y, 48'h8000_8000_8000);
        write_reg(REG_MATRIX_ROW_Z, 48'hFFFF_FFFF_FFFF);
        write_reg(cfg_index_t'(3'd7), 48'h1234_5678_9ABC); // unused index, ignored
        send_point(8'd255, 10'd1023, 1'b0);
        send_point(8'd255, 10'd1, 1'b0);
        send_point(8'd0, 10'd1023, 1'b0);
        send_point(8'd170, 10'd341, 1'b0);
        send_point(8'd85, 10'd682, 1'b0);
        stop_sending();
        wait_drained();

        // zero radial step, angle step and x row; extreme height registers
        write_reg(REG_RADIAL_STEP, 48'd0);
        write_reg(REG_ANGLE_STEP, 48'd0);
        write_reg(REG_Z_STEP, 48'h0000_8000_0000);
        write_reg(REG_Z_OFFSET, 48'h0000_7FFF_FFFF);
        write_reg(REG_MATRIX_ROW_X, 48'd0);
        send_point(8'd255, 10'd1023, 1'b0);
        send_point(8'd3, 10'd2, 1'b0);
        stop_sending();
        wait_drained();

        // long receiver hold while the sender keeps offering: fill the pipeline
        random_settings();
        hold_receiver = 1'b1;
        fork
            begin
                repeat (LATENCY * 4) @(negedge aclk);
                hold_receiver = 1'b0;
            end
            for (int n = 0; n < 60; n++)
                send_point(8'($urandom), 10'($urandom), 1'b0);
        join
        stop_sending();
        wait_drained();

        // random phases under fresh settings, sender pausing between items in two phases of every three
        for (int phase_no = 0; phase_no < 14; phase_no++) begin
            random_settings();
            for (int n = 0; n < 120; n++)
                send_point(8'($urandom), 10'($urandom), phase_no % 3 != 2);
            stop_sending();
            wait_drained();
        end

        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
`default_nettype wire

### helical_point_transform_unit.f
+incdir+sv
sv/hpt_pkg.sv
sv/hpt_front.sv
sv/hpt_cordic.sv
sv/hpt_matrix.sv
sv/helical_point_transform_unit.sv
sv/hpt_checker.sv
test/helical_point_transform_checker.sv
test/helical_point_transform_unit_tb.sv
